[hw/rtl/aes_pkg.sv]
// aes_pkg: shared types, s-box tables and round helpers for the aes-128 pipeline
// depends on nothing; used by aes_key_sched, aes_round and aes128_block_cipher
`timescale 1ns / 1ps
`default_nettype none

package aes_pkg;

    localparam int NumRounds = 10;

    localparam logic [0:0] OpEncrypt = 1'b0;
    localparam logic [0:0] OpDecrypt = 1'b1;

    localparam logic [0:0] CfgKeyHigh = 1'b0;
    localparam logic [0:0] CfgKeyLow  = 1'b1;

    typedef logic [127:0] block_t;

    // control that travels with a word through the round stages
    typedef struct packed {
        logic       valid;
        logic [0:0] op;
    } stage_ctl_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r=8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h52; 8'h01: r=8'h09; 8'h02: r=8'h6a; 8'h03: r=8'hd5;
            8'h04: r=8'h30; 8'h05: r=8'h36; 8'h06: r=8'ha5; 8'h07: r=8'h38;
            8'h08: r=8'hbf; 8'h09: r=8'h40; 8'h0a: r=8'ha3; 8'h0b: r=8'h9e;
            8'h0c: r=8'h81; 8'h0d: r=8'hf3; 8'h0e: r=8'hd7; 8'h0f: r=8'hfb;
            8'h10: r=8'h7c; 8'h11: r=8'he3; 8'h12: r=8'h39; 8'h13: r=8'h82;
            8'h14: r=8'h9b; 8'h15: r=8'h2f; 8'h16: r=8'hff; 8'h17: r=8'h87;
            8'h18: r=8'h34; 8'h19: r=8'h8e; 8'h1a: r=8'h43; 8'h1b: r=8'h44;
            8'h1c: r=8'hc4; 8'h1d: r=8'hde; 8'h1e: r=8'he9; 8'h1f: r=8'hcb;
            8'h20: r=8'h54; 8'h21: r=8'h7b; 8'h22: r=8'h94; 8'h23: r=8'h32;
            8'h24: r=8'ha6; 8'h25: r=8'hc2; 8'h26: r=8'h23; 8'h27: r=8'h3d;
            8'h28: r=8'hee; 8'h29: r=8'h4c; 8'h2a: r=8'h95; 8'h2b: r=8'h0b;
            8'h2c: r=8'h42; 8'h2d: r=8'hfa; 8'h2e: r=8'hc3; 8'h2f: r=8'h4e;
            8'h30: r=8'h08; 8'h31: r=8'h2e; 8'h32: r=8'ha1; 8'h33: r=8'h66;
            8'h34: r=8'h28; 8'h35: r=8'hd9; 8'h36: r=8'h24; 8'h37: r=8'hb2;
            8'h38: r=8'h76; 8'h39: r=8'h5b; 8'h3a: r=8'ha2; 8'h3b: r=8'h49;
            8'h3c: r=8'h6d; 8'h3d: r=8'h8b; 8'h3e: r=8'hd1; 8'h3f: r=8'h25;
            8'h40: r=8'h72; 8'h41: r=8'hf8; 8'h42: r=8'hf6; 8'h43: r=8'h64;
            8'h44: r=8'h86; 8'h45: r=8'h68; 8'h46: r=8'h98; 8'h47: r=8'h16;
            8'h48: r=8'hd4; 8'h49: r=8'ha4; 8'h4a: r=8'h5c; 8'h4b: r=8'hcc;
            8'h4c: r=8'h5d; 8'h4d: r=8'h65; 8'h4e: r=8'hb6; 8'h4f: r=8'h92;
            8'h50: r=8'h6c; 8'h51: r=8'h70; 8'h52: r=8'h48; 8'h53: r=8'h50;
            8'h54: r=8'hfd; 8'h55: r=8'hed; 8'h56: r=8'hb9; 8'h57: r=8'hda;
            8'h58: r=8'h5e; 8'h59: r=8'h15; 8'h5a: r=8'h46; 8'h5b: r=8'h57;
            8'h5c: r=8'ha7; 8'h5d: r=8'h8d; 8'h5e: r=8'h9d; 8'h5f: r=8'h84;
            8'h60: r=8'h90; 8'h61: r=8'hd8; 8'h62: r=8'hab; 8'h63: r=8'h00;
            8'h64: r=8'h8c; 8'h65: r=8'hbc; 8'h66: r=8'hd3; 8'h67: r=8'h0a;
            8'h68: r=8'hf7; 8'h69: r=8'he4; 8'h6a: r=8'h58; 8'h6b: r=8'h05;
            8'h6c: r=8'hb8; 8'h6d: r=8'hb3; 8'h6e: r=8'h45; 8'h6f: r=8'h06;
            8'h70: r=8'hd0; 8'h71: r=8'h2c; 8'h72: r=8'h1e; 8'h73: r=8'h8f;
            8'h74: r=8'hca; 8'h75: r=8'h3f; 8'h76: r=8'h0f; 8'h77: r=8'h02;
            8'h78: r=8'hc1; 8'h79: r=8'haf; 8'h7a: r=8'hbd; 8'h7b: r=8'h03;
            8'h7c: r=8'h01; 8'h7d: r=8'h13; 8'h7e: r=8'h8a; 8'h7f: r=8'h6b;
            8'h80: r=8'h3a; 8'h81: r=8'h91; 8'h82: r=8'h11; 8'h83: r=8'h41;
            8'h84: r=8'h4f; 8'h85: r=8'h67; 8'h86: r=8'hdc; 8'h87: r=8'hea;
            8'h88: r=8'h97; 8'h89: r=8'hf2; 8'h8a: r=8'hcf; 8'h8b: r=8'hce;
            8'h8c: r=8'hf0; 8'h8d: r=8'hb4; 8'h8e: r=8'he6; 8'h8f: r=8'h73;
            8'h90: r=8'h96; 8'h91: r=8'hac; 8'h92: r=8'h74; 8'h93: r=8'h22;
            8'h94: r=8'he7; 8'h95: r=8'had; 8'h96: r=8'h35; 8'h97: r=8'h85;
            8'h98: r=8'he2; 8'h99: r=8'hf9; 8'h9a: r=8'h37; 8'h9b: r=8'he8;
            8'h9c: r=8'h1c; 8'h9d: r=8'h75; 8'h9e: r=8'hdf; 8'h9f: r=8'h6e;
            8'ha0: r=8'h47; 8'ha1: r=8'hf1; 8'ha2: r=8'h1a; 8'ha3: r=8'h71;
            8'ha4: r=8'h1d; 8'ha5: r=8'h29; 8'ha6: r=8'hc5; 8'ha7: r=8'h89;
            8'ha8: r=8'h6f; 8'ha9: r=8'hb7; 8'haa: r=8'h62; 8'hab: r=8'h0e;
            8'hac: r=8'haa; 8'had: r=8'h18; 8'hae: r=8'hbe; 8'haf: r=8'h1b;
            8'hb0: r=8'hfc; 8'hb1: r=8'h56; 8'hb2: r=8'h3e; 8'hb3: r=8'h4b;
            8'hb4: r=8'hc6; 8'hb5: r=8'hd2; 8'hb6: r=8'h79; 8'hb7: r=8'h20;
            8'hb8: r=8'h9a; 8'hb9: r=8'hdb; 8'hba: r=8'hc0; 8'hbb: r=8'hfe;
            8'hbc: r=8'h78; 8'hbd: r=8'hcd; 8'hbe: r=8'h5a; 8'hbf: r=8'hf4;
            8'hc0: r=8'h1f; 8'hc1: r=8'hdd; 8'hc2: r=8'ha8; 8'hc3: r=8'h33;
            8'hc4: r=8'h88; 8'hc5: r=8'h07; 8'hc6: r=8'hc7; 8'hc7: r=8'h31;
            8'hc8: r=8'hb1; 8'hc9: r=8'h12; 8'hca: r=8'h10; 8'hcb: r=8'h59;
            8'hcc: r=8'h27; 8'hcd: r=8'h80; 8'hce: r=8'hec; 8'hcf: r=8'h5f;
            8'hd0: r=8'h60; 8'hd1: r=8'h51; 8'hd2: r=8'h7f; 8'hd3: r=8'ha9;
            8'hd4: r=8'h19; 8'hd5: r=8'hb5; 8'hd6: r=8'h4a; 8'hd7: r=8'h0d;
            8'hd8: r=8'h2d; 8'hd9: r=8'he5; 8'hda: r=8'h7a; 8'hdb: r=8'h9f;
            8'hdc: r=8'h93; 8'hdd: r=8'hc9; 8'hde: r=8'h9c; 8'hdf: r=8'hef;
            8'he0: r=8'ha0; 8'he1: r=8'he0; 8'he2: r=8'h3b; 8'he3: r=8'h4d;
            8'he4: r=8'hae; 8'he5: r=8'h2a; 8'he6: r=8'hf5; 8'he7: r=8'hb0;
            8'he8: r=8'hc8; 8'he9: r=8'heb; 8'hea: r=8'hbb; 8'heb: r=8'h3c;
            8'hec: r=8'h83; 8'hed: r=8'h53; 8'hee: r=8'h99; 8'hef: r=8'h61;
            8'hf0: r=8'h17; 8'hf1: r=8'h2b; 8'hf2: r=8'h04; 8'hf3: r=8'h7e;
            8'hf4: r=8'hba; 8'hf5: r=8'h77; 8'hf6: r=8'hd6; 8'hf7: r=8'h26;
            8'hf8: r=8'he1; 8'hf9: r=8'h69; 8'hfa: r=8'h14; 8'hfb: r=8'h63;
            8'hfc: r=8'h55; 8'hfd: r=8'h21; 8'hfe: r=8'h0c; 8'hff: r=8'h7d;
            default: r=8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // byte n of the block in fips order, byte 0 topmost
    function automatic logic [7:0] get_byte(input block_t s, input int n);
        return s[127 - 8*n -: 8];
    endfunction

    // subbytes and shiftrows, forward or inverse
    function automatic block_t sub_shift(input block_t s, input logic inv);
        block_t t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (inv) begin
                    t[127 - 8*(((c + r) % 4)*4 + r) -: 8] = inv_sbox(get_byte(s, c*4 + r));
                end else begin
                    t[127 - 8*(c*4 + r) -: 8] = sbox(get_byte(s, ((c + r) % 4)*4 + r));
                end
            end
        end
        return t;
    endfunction

    function automatic block_t mix_fwd(input block_t s);
        block_t t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, c*4);
            a1 = get_byte(s, c*4 + 1);
            a2 = get_byte(s, c*4 + 2);
            a3 = get_byte(s, c*4 + 3);
            t[127 - 32*c -: 8]      = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[127 - 32*c - 8 -: 8]  = xtime(a1) ^ xtime(a2) ^ a2 ^ a3 ^ a0;
            t[127 - 32*c - 16 -: 8] = xtime(a2) ^ xtime(a3) ^ a3 ^ a0 ^ a1;
            t[127 - 32*c - 24 -: 8] = xtime(a3) ^ xtime(a0) ^ a0 ^ a1 ^ a2;
        end
        return t;
    endfunction

    // inverse mixcolumns as a pre-step on the forward one
    function automatic block_t mix_inv(input block_t s);
        block_t t;
        logic [7:0] u, v;
        for (int c = 0; c < 4; c++) begin
            u = xtime(xtime(get_byte(s, c*4) ^ get_byte(s, c*4 + 2)));
            v = xtime(xtime(get_byte(s, c*4 + 1) ^ get_byte(s, c*4 + 3)));
            t[127 - 32*c -: 8]      = get_byte(s, c*4) ^ u;
            t[127 - 32*c - 8 -: 8]  = get_byte(s, c*4 + 1) ^ v;
            t[127 - 32*c - 16 -: 8] = get_byte(s, c*4 + 2) ^ u;
            t[127 - 32*c - 24 -: 8] = get_byte(s, c*4 + 3) ^ v;
        end
        return mix_fwd(t);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/aes_key_sched.sv]
// aes_key_sched: expands the configured key into the eleven round keys
// depends on aes_pkg; one expansion step per register stage after a key write
`timescale 1ns / 1ps
`default_nettype none

module aes_key_sched (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire  [127:0]         key,
    output logic [11*128-1:0]    round_keys
);
    import aes_pkg::*;

    localparam logic [7:0] RconFirst = 8'h01;

    logic [127:0] rk_reg  [0:10];
    logic [127:0] rk_next [1:10];
    logic [7:0]   rcon    [0:10];

    assign rcon[0] = RconFirst;

    // rk_reg[0] follows the key registers; each later stage derives from the one before
    always_ff @(posedge aclk) begin
        rk_reg[0] <= key;
        for (int i = 1; i <= 10; i++) begin
            rk_reg[i] <= rk_next[i];
        end
    end

    genvar g;
    generate
        for (g = 1; g <= 10; g++) begin : g_step
            logic [31:0] w0, w1, w2, w3, tw;
            assign rcon[g] = xtime(rcon[g-1]);
            assign tw = {sbox(rk_reg[g-1][23:16]) ^ rcon[g-1], sbox(rk_reg[g-1][15:8]),
                         sbox(rk_reg[g-1][7:0]), sbox(rk_reg[g-1][31:24])};
            assign w0 = rk_reg[g-1][127:96] ^ tw;
            assign w1 = rk_reg[g-1][95:64] ^ w0;
            assign w2 = rk_reg[g-1][63:32] ^ w1;
            assign w3 = rk_reg[g-1][31:0] ^ w2;
            assign rk_next[g] = {w0, w1, w2, w3};
        end
        for (g = 0; g <= 10; g++) begin : g_out
            assign round_keys[g*128 +: 128] = rk_reg[g];
        end
    endgenerate

    logic unused_ok;
    assign unused_ok = ^{aresetn, rcon[10]};

endmodule

`default_nettype wire

[hw/rtl/aes_round.sv]
// aes_round: one registered cipher round, forward or inverse, with a hold on stall
// depends on aes_pkg
`timescale 1ns / 1ps
`default_nettype none

module aes_round (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      advance,
    input  wire  aes_pkg::stage_ctl_t ctl_in,
    input  wire  aes_pkg::block_t    state_in,
    input  wire  aes_pkg::block_t    key_enc,
    input  wire  aes_pkg::block_t    key_dec,
    input  wire                      last_round,
    output aes_pkg::stage_ctl_t      ctl_out,
    output aes_pkg::block_t          state_out
);
    import aes_pkg::*;

    logic       valid_reg;
    logic [0:0] op_reg;
    block_t     state_reg, state_next, ss;

    // enc: sub/shift, mix, key; dec: inv sub/shift, key, inv mix; last round has no mix
    always_comb begin
        ss = sub_shift(state_in, ctl_in.op == OpDecrypt);
        if (ctl_in.op == OpDecrypt) begin
            state_next = last_round ? (ss ^ key_dec) : mix_inv(ss ^ key_dec);
        end else begin
            state_next = (last_round ? ss : mix_fwd(ss)) ^ key_enc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            op_reg    <= ctl_in.op;
            state_reg <= state_next;
        end
    end

    assign ctl_out   = '{valid: valid_reg, op: op_reg};
    assign state_out = state_reg;

endmodule

`default_nettype wire

[hw/rtl/aes128_block_cipher.sv]
// aes128_block_cipher: an accepted word passes through the input stage, ten
// round stages and the output register; one word per cycle sustained while not
// stalled, set by the ten unrolled round stages. a stall freezes the whole pipe.
// round keys settle after a key write or reset; input held off till then.
// synchronous active-low reset clears the valid bits and both key registers to zero.
// depends on aes_pkg, aes_key_sched, aes_round
`timescale 1ns / 1ps
`default_nettype none

module aes128_block_cipher (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          cfg_we,
    input  wire  [0:0]   cfg_index,
    input  wire  [63:0]  cfg_data,
    input  wire          s_valid,
    output logic         s_ready,
    input  wire  [0:0]   s_operation,
    input  wire  [63:0]  s_block_high,
    input  wire  [63:0]  s_block_low,
    output logic         m_valid,
    input  wire          m_ready,
    output logic [63:0]  m_result_high,
    output logic [63:0]  m_result_low
);
    import aes_pkg::*;

    // cycles from a key register update until round key 10 is current
    localparam logic [3:0] KeySettleCycles = 4'd11;

    // key registers
    logic [63:0] key_high_reg, key_low_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CfgKeyHigh: key_high_reg <= cfg_data;
                CfgKeyLow:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // round key pipeline, each round key held statically once settled
    logic [11*128-1:0] round_keys;

    aes_key_sched u_key_sched (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .key        ({key_high_reg, key_low_reg}),
        .round_keys (round_keys)
    );

    // count down while the round keys ripple through the schedule
    logic [3:0] settle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= KeySettleCycles;
        end else if (cfg_we) begin
            settle_reg <= KeySettleCycles;
        end else if (settle_reg != 4'd0) begin
            settle_reg <= settle_reg - 4'd1;
        end
    end

    // whole pipe advances together unless the output word is stuck
    logic advance;
    assign advance = !m_valid || m_ready;
    assign s_ready = advance && !cfg_we && (settle_reg == 4'd0);

    // input stage: initial whitening with round key 0 or round key 10
    stage_ctl_t ctl_s   [0:NumRounds];
    block_t     state_s [0:NumRounds];
    logic       valid0_reg;
    logic [0:0] op0_reg;
    block_t     state0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid0_reg <= 1'b0;
        end else if (advance) begin
            valid0_reg <= s_valid && s_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            op0_reg    <= s_operation;
            state0_reg <= {s_block_high, s_block_low} ^
                          ((s_operation == OpDecrypt) ? round_keys[10*128 +: 128]
                                                      : round_keys[0 +: 128]);
        end
    end

    assign ctl_s[0]   = '{valid: valid0_reg, op: op0_reg};
    assign state_s[0] = state0_reg;

    // ten round stages; decrypt stage r uses key 10-r
    genvar r;
    generate
        for (r = 1; r <= NumRounds; r++) begin : g_round
            aes_round u_round (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .advance    (advance),
                .ctl_in     (ctl_s[r-1]),
                .state_in   (state_s[r-1]),
                .key_enc    (round_keys[r*128 +: 128]),
                .key_dec    (round_keys[(NumRounds-r)*128 +: 128]),
                .last_round (r == NumRounds),
                .ctl_out    (ctl_s[r]),
                .state_out  (state_s[r])
            );
        end
    endgenerate

    // output register
    logic   m_valid_reg;
    block_t result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= ctl_s[NumRounds].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= state_s[NumRounds];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_high = result_reg[127:64];
    assign m_result_low  = result_reg[63:0];

    logic unused_ok;
    assign unused_ok = ctl_s[NumRounds].op[0];

endmodule

`default_nettype wire

[test/testbench.sv]
// testbench: checks the aes-128 ecb cipher against its own in-bench predictor
// depends on aes_pkg (op and register codes) and aes128_block_cipher
`timescale 1ns / 1ps

module testbench;
    import aes_pkg::*;

    typedef struct {
        logic [0:0]  op;
        logic [63:0] hi;
        logic [63:0] lo;
    } word_t;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } cipher_out_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        s_valid;
    wire         s_ready;
    logic [0:0]  s_operation;
    logic [63:0] s_block_high;
    logic [63:0] s_block_low;
    wire         m_valid;
    logic        m_ready;
    wire  [63:0] m_result_high;
    wire  [63:0] m_result_low;

    aes128_block_cipher dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_block_high(s_block_high), .s_block_low(s_block_low),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_high(m_result_high), .m_result_low(m_result_low)
    );

    // predictor's copy of the key registers
    logic [63:0] key_hi_shadow;
    logic [63:0] key_lo_shadow;

    word_t       pending_words[$];
    cipher_out_t expected_blocks[$];
    int          error_count;
    int          hold_off_cycles;
    int          send_gap;
    int          recv_gap;

    // ---- predictor ----
    logic [7:0] fwd_tab[256];
    logic [7:0] rev_tab[256];

    function automatic logic [7:0] gmul2(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 0;
        for (int i = 0; i < 8; i++) begin
            if (a[i]) acc ^= b;
            b = gmul2(b);
        end
        return acc;
    endfunction

    // build s-box tables by field inversion plus affine map
    task automatic build_tables();
        logic [7:0] inv, y;
        for (int x = 0; x < 256; x++) begin
            inv = 0;
            for (int j = 1; j < 256; j++)
                if (gmul(x[7:0], j[7:0]) == 8'h01) inv = j[7:0];
            y = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            fwd_tab[x] = y;
            rev_tab[y] = x[7:0];
        end
    endtask

    function automatic cipher_out_t aes_predict(input word_t w);
        logic [7:0] rk[176];
        logic [7:0] st[16];
        logic [7:0] tmp[16];
        logic [7:0] col[4];
        logic [7:0] t[4];
        logic [7:0] rcon, x;
        logic [127:0] k, b, r;
        cipher_out_t res;
        k = {key_hi_shadow, key_lo_shadow};
        b = {w.hi, w.lo};
        for (int i = 0; i < 16; i++) begin
            rk[i] = k[127 - 8*i -: 8];
            st[i] = b[127 - 8*i -: 8];
        end
        rcon = 8'h01;
        for (int i = 4; i < 44; i++) begin
            for (int j = 0; j < 4; j++) t[j] = rk[(i-1)*4 + j];
            if ((i % 4) == 0) begin
                x = t[0];
                t[0] = fwd_tab[t[1]] ^ rcon;
                t[1] = fwd_tab[t[2]];
                t[2] = fwd_tab[t[3]];
                t[3] = fwd_tab[x];
                rcon = gmul2(rcon);
            end
            for (int j = 0; j < 4; j++) rk[i*4 + j] = rk[(i-4)*4 + j] ^ t[j];
        end
        if (w.op == OpEncrypt) begin
            for (int i = 0; i < 16; i++) st[i] ^= rk[i];
            for (int rnd = 1; rnd <= NumRounds; rnd++) begin
                for (int c = 0; c < 4; c++)
                    for (int rw = 0; rw < 4; rw++)
                        tmp[c*4 + rw] = fwd_tab[st[((c + rw) % 4)*4 + rw]];
                st = tmp;
                if (rnd != NumRounds) begin
                    for (int c = 0; c < 4; c++) begin
                        for (int rw = 0; rw < 4; rw++) col[rw] = st[c*4 + rw];
                        for (int rw = 0; rw < 4; rw++)
                            st[c*4 + rw] = gmul(8'h02, col[rw]) ^ gmul(8'h03, col[(rw+1)%4])
                                           ^ col[(rw+2)%4] ^ col[(rw+3)%4];
                    end
                end
                for (int i = 0; i < 16; i++) st[i] ^= rk[rnd*16 + i];
            end
        end else begin
            for (int i = 0; i < 16; i++) st[i] ^= rk[160 + i];
            for (int rnd = NumRounds - 1; rnd >= 0; rnd--) begin
                for (int c = 0; c < 4; c++)
                    for (int rw = 0; rw < 4; rw++)
                        tmp[((c + rw) % 4)*4 + rw] = rev_tab[st[c*4 + rw]];
                st = tmp;
                for (int i = 0; i < 16; i++) st[i] ^= rk[rnd*16 + i];
                if (rnd != 0) begin
                    for (int c = 0; c < 4; c++) begin
                        for (int rw = 0; rw < 4; rw++) col[rw] = st[c*4 + rw];
                        for (int rw = 0; rw < 4; rw++)
                            st[c*4 + rw] = gmul(8'h0e, col[rw]) ^ gmul(8'h0b, col[(rw+1)%4])
                                           ^ gmul(8'h0d, col[(rw+2)%4])
                                           ^ gmul(8'h09, col[(rw+3)%4]);
                    end
                end
            end
        end
        for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = st[i];
        res.hi = r[127:64];
        res.lo = r[63:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch %s", msg);
        error_count++;
    endtask

    // ---- clock ----
    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // ---- driver: sends queued words, predicting each one on acceptance ----
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_blocks.push_back(aes_predict('{s_operation, s_block_high,
                                                        s_block_low}));
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0 || pending_words.size() == 0) begin
                    s_valid <= 0;
                    if (send_gap > 0) send_gap <= send_gap - 1;
                end else begin
                    word_t w;
                    w = pending_words.pop_front();
                    s_valid      <= 1;
                    s_operation  <= w.op;
                    s_block_high <= w.hi;
                    s_block_low  <= w.lo;
                    // gap before the following word
                    send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
                end
            end
        end
    end

    // ---- monitor: checks each result against the oldest prediction ----
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
            recv_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_blocks.size() == 0) begin
                    report_mismatch($sformatf("unexpected result word %h_%h",
                                              m_result_high, m_result_low));
                end else begin
                    cipher_out_t e;
                    e = expected_blocks.pop_front();
                    if (m_result_high !== e.hi)
                        report_mismatch($sformatf("result_high: got %h want %h",
                                                  m_result_high, e.hi));
                    if (m_result_low !== e.lo)
                        report_mismatch($sformatf("result_low: got %h want %h",
                                                  m_result_low, e.lo));
                end
            end
            if (hold_off_cycles > 0) begin
                // long back-pressure so the pipe fills and stalls its input
                hold_off_cycles <= hold_off_cycles - 1;
                m_ready <= 0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 0;
            end else begin
                m_ready <= 1;
                if (m_valid && m_ready)
                    recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            end
        end
    end

    task automatic queue_word(input logic [0:0] op, input logic [63:0] hi,
                              input logic [63:0] lo);
        pending_words.push_back('{op, hi, lo});
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // wait for all outstanding words to drain, then let the key schedule settle
    task automatic drain_pipe();
        while (pending_words.size() != 0 || s_valid || expected_blocks.size() != 0)
            @(negedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_key(input logic [0:0] idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 0;
        if (idx == CfgKeyHigh) key_hi_shadow = val;
        else key_lo_shadow = val;
        repeat (14) @(posedge aclk);
    endtask

    // ---- stimulus ----
    initial begin
        logic [63:0] ph, pl;
        cfg_we = 0; cfg_index = CfgKeyHigh; cfg_data = 0;
        s_valid = 0; s_operation = OpEncrypt; s_block_high = 0; s_block_low = 0;
        m_ready = 0;
        aresetn = 0;
        error_count = 0;
        hold_off_cycles = 0;
        key_hi_shadow = 0;
        key_lo_shadow = 0;
        build_tables();
        repeat (4) @(posedge aclk);
        aresetn <= 1;

        // reset key of all zeros, extremes of the block
        queue_word(OpEncrypt, 64'h0, 64'h0);
        queue_word(OpDecrypt, 64'h0, 64'h0);
        queue_word(OpEncrypt, '1, '1);
        queue_word(OpDecrypt, '1, '1);
        drain_pipe();

        // fips-197 appendix c.1 key and vector
        write_key(CfgKeyHigh, 64'h0001020304050607);
        write_key(CfgKeyLow, 64'h08090a0b0c0d0e0f);
        queue_word(OpEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff);
        queue_word(OpDecrypt, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        queue_word(OpEncrypt, 64'h8000000000000000, 64'h1);
        queue_word(OpDecrypt, 64'h8000000000000000, 64'h1);
        drain_pipe();

        // all-ones key
        write_key(CfgKeyHigh, '1);
        write_key(CfgKeyLow, '1);
        queue_word(OpEncrypt, 64'h0, '1);
        queue_word(OpDecrypt, '1, 64'h0);
        drain_pipe();

        // random phases under varying keys; one phase with a long stall
        for (int phase = 0; phase < 8; phase++) begin
            write_key(CfgKeyHigh, rand64());
            write_key(CfgKeyLow, rand64());
            for (int n = 0; n < 104; n++) begin
                ph = rand64();
                pl = rand64();
                queue_word(1'($urandom_range(0, 1)), ph, pl);
                // round trip: decrypt what the block should have produced
                if ($urandom_range(0, 3) == 0) begin
                    cipher_out_t c;
                    c = aes_predict('{OpEncrypt, ph, pl});
                    queue_word(OpDecrypt, c.hi, c.lo);
                end
            end
            if (phase == 2) hold_off_cycles = 300;
            drain_pipe();
        end

        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // ---- watchdog ----
    initial begin
        #3000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
